@@ design/cdq_pkg.sv @@
// Shared types and constants for the circular double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_REAR,
    CELL_POP_FRONT,
    CELL_POP_REAR,
    CELL_ROT_FWD,
    CELL_ROT_BWD
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [DATA_W-1:0]   value;
  } cell_cmd_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_ROTATE
  } fsm_t;

endpackage

`default_nettype wire

@@ design/circular_double_ended_queue.sv @@
// Top level of the double-ended queue: sequencer and a ring of storage cells.
//
//   channel   direction  handshake                 payload
//   request   in         start / busy              in_req_type, in_push_value
//   result    out        out_valid (1-cycle pulse) out_pop_value, out_status, out_occupancy
//
// A push, a refused request, or a pop from a side whose part of the ring holds
// entries never raises busy; the result appears the cycle after the transaction.
// A pop from an end whose part is empty rotates the ring one cell a cycle: with
// n entries held it holds busy through n shifts and then the pop, and its result
// is registered from that pop.
// Reset is synchronous and clears the counts; cell contents stay undefined and
// need no clearing pass. The receiver cannot stall: each result shows once.
`timescale 1ns / 1ps
`default_nettype none

module circular_double_ended_queue
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_req_type,
  input  wire logic signed [DATA_W-1:0] in_push_value,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_pop_value,
  output logic [1:0]                    out_status,
  output logic [CNT_W-1:0]              out_occupancy
);

  cell_cmd_t                cmd;
  logic [CNT_W-1:0]         front_cnt, rear_cnt;
  logic signed [DATA_W-1:0] cell_data [DEPTH];

  cdq_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .front_data    (cell_data[0]),
    .rear_data     (cell_data[DEPTH-1]),
    .cmd           (cmd),
    .front_cnt     (front_cnt),
    .rear_cnt      (rear_cnt),
    .out_valid     (out_valid),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cdq_cell #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .front_cnt  (front_cnt),
      .rear_cnt   (rear_cnt),
      .left_data  (cell_data[(i + DEPTH - 1) % DEPTH]),
      .right_data (cell_data[(i + 1) % DEPTH]),
      .data       (cell_data[i])
    );
  end

endmodule

`default_nettype wire

@@ design/cdq_cell.sv @@
// One storage cell of the ring: holds a word and moves it to or from its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1),
  parameter int INDEX = 0
) (
  input  wire logic                     clk,
  input  wire cell_cmd_t                cmd,
  input  wire logic [CNT_W-1:0]         front_cnt,
  input  wire logic [CNT_W-1:0]         rear_cnt,
  input  wire logic signed [DATA_W-1:0] left_data,
  input  wire logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0]      data
);

  localparam logic [CNT_W:0] IDX   = (CNT_W + 1)'(INDEX);
  localparam logic [CNT_W:0] IDX1  = (CNT_W + 1)'(INDEX + 1);
  localparam logic [CNT_W:0] DEP   = (CNT_W + 1)'(DEPTH);
  localparam bit             FIRST = (INDEX == 0);
  localparam bit             LAST  = (INDEX == DEPTH - 1);

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic [CNT_W:0]           front_x, rear_x;

  assign front_x = {1'b0, front_cnt};
  assign rear_x  = {1'b0, rear_cnt};

  // The front part grows up from cell 0, the rear part down from the last cell.
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_HOLD: ;
      CELL_PUSH_FRONT: begin
        if (FIRST) data_nxt = cmd.value;
        else if (IDX <= front_x) data_nxt = left_data;
      end
      CELL_PUSH_REAR: begin
        if (LAST) data_nxt = cmd.value;
        else if (IDX1 + rear_x >= DEP) data_nxt = right_data;
      end
      CELL_POP_FRONT: begin
        if (IDX1 < front_x) data_nxt = right_data;
      end
      CELL_POP_REAR: begin
        if (IDX + rear_x > DEP) data_nxt = left_data;
      end
      CELL_ROT_FWD: data_nxt = left_data;
      CELL_ROT_BWD: data_nxt = right_data;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

@@ design/cdq_ctrl.sv @@
// Request sequencer: part counts, ring rotation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_req_type,
  input  wire logic signed [DATA_W-1:0] in_push_value,
  input  wire logic signed [DATA_W-1:0] front_data,
  input  wire logic signed [DATA_W-1:0] rear_data,
  output cell_cmd_t                     cmd,
  output logic [CNT_W-1:0]              front_cnt,
  output logic [CNT_W-1:0]              rear_cnt,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_pop_value,
  output logic [1:0]                    out_status,
  output logic [CNT_W-1:0]              out_occupancy
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  fsm_t                     state_r, state_nxt;
  logic [CNT_W-1:0]         front_cnt_r, front_cnt_nxt;
  logic [CNT_W-1:0]         rear_cnt_r, rear_cnt_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic                     pend_front_r, pend_front_nxt;
  logic [CNT_W-1:0]         count;
  logic                     accept;
  logic                     need_rot;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_pop_value_r, out_pop_value_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [CNT_W-1:0]         out_occupancy_r, out_occupancy_nxt;

  assign count  = front_cnt_r + rear_cnt_r;
  assign accept = start && (state_r == FSM_IDLE);
  // A pop from a side whose part is empty: the whole queue sits on the other side.
  assign need_rot = (count != '0) &&
                    (((in_req_type == REQ_POP_FRONT) && (front_cnt_r == '0)) ||
                     ((in_req_type == REQ_POP_REAR) && (rear_cnt_r == '0)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE:   if (accept && need_rot) state_nxt = FSM_ROTATE;
      FSM_ROTATE: if (rem_r == '0) state_nxt = FSM_IDLE;
      default:    state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd.op            = CELL_HOLD;
    cmd.value         = in_push_value;
    front_cnt_nxt     = front_cnt_r;
    rear_cnt_nxt      = rear_cnt_r;
    rem_nxt           = rem_r;
    pend_front_nxt    = pend_front_r;
    out_valid_nxt     = 1'b0;
    out_pop_value_nxt = '0;
    out_status_nxt    = ST_OK;
    out_occupancy_nxt = count;
    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          unique case (req_type_t'(in_req_type))
            REQ_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (count == FULL_CNT) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.op            = CELL_PUSH_FRONT;
                front_cnt_nxt     = front_cnt_r + ONE;
                out_occupancy_nxt = count + ONE;
              end
            end
            REQ_PUSH_REAR: begin
              out_valid_nxt = 1'b1;
              if (count == FULL_CNT) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.op            = CELL_PUSH_REAR;
                rear_cnt_nxt      = rear_cnt_r + ONE;
                out_occupancy_nxt = count + ONE;
              end
            end
            REQ_POP_FRONT: begin
              if (count == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else if (front_cnt_r != '0) begin
                out_valid_nxt     = 1'b1;
                cmd.op            = CELL_POP_FRONT;
                out_pop_value_nxt = front_data;
                front_cnt_nxt     = front_cnt_r - ONE;
                out_occupancy_nxt = count - ONE;
              end else begin
                // rotate the rear part round to cell 0
                rem_nxt        = rear_cnt_r;
                front_cnt_nxt  = count;
                rear_cnt_nxt   = '0;
                pend_front_nxt = 1'b1;
              end
            end
            REQ_POP_REAR: begin
              if (count == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else if (rear_cnt_r != '0) begin
                out_valid_nxt     = 1'b1;
                cmd.op            = CELL_POP_REAR;
                out_pop_value_nxt = rear_data;
                rear_cnt_nxt      = rear_cnt_r - ONE;
                out_occupancy_nxt = count - ONE;
              end else begin
                rem_nxt        = front_cnt_r;
                rear_cnt_nxt   = count;
                front_cnt_nxt  = '0;
                pend_front_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_ROTATE: begin
        if (rem_r != '0) begin
          cmd.op  = pend_front_r ? CELL_ROT_FWD : CELL_ROT_BWD;
          rem_nxt = rem_r - ONE;
        end else begin
          out_valid_nxt     = 1'b1;
          out_occupancy_nxt = count - ONE;
          if (pend_front_r) begin
            cmd.op            = CELL_POP_FRONT;
            out_pop_value_nxt = front_data;
            front_cnt_nxt     = front_cnt_r - ONE;
          end else begin
            cmd.op            = CELL_POP_REAR;
            out_pop_value_nxt = rear_data;
            rear_cnt_nxt      = rear_cnt_r - ONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_IDLE;
      front_cnt_r  <= '0;
      rear_cnt_r   <= '0;
      rem_r        <= '0;
      pend_front_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_cnt_r  <= front_cnt_nxt;
      rear_cnt_r   <= rear_cnt_nxt;
      rem_r        <= rem_nxt;
      pend_front_r <= pend_front_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pop_value_r <= out_pop_value_nxt;
    out_status_r    <= out_status_nxt;
    out_occupancy_r <= out_occupancy_nxt;
  end

  assign busy          = (state_r != FSM_IDLE);
  assign front_cnt     = front_cnt_r;
  assign rear_cnt      = rear_cnt_r;
  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

endmodule

`default_nettype wire

@@ design/cdq_checker.sv @@
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cdq_checker
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     out_valid,
  input wire logic signed [DATA_W-1:0] out_pop_value,
  input wire logic [1:0]               out_status,
  input wire logic [CNT_W-1:0]         out_occupancy
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // an accepted transaction either answers next cycle or starts a rotation
  a_answer_or_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted request gave neither result nor busy");

  a_rotate_ends_in_result : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("rotation finished without a result");

  a_refused_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_pop_value == '0)
    else $error("refused request carries data");

  a_full_occupancy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_occupancy == FULL_CNT)
    else $error("full status with occupancy below depth");

  a_empty_occupancy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_occupancy == '0)
    else $error("empty status with entries held");

endmodule

bind circular_double_ended_queue cdq_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_cdq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_pop_value (out_pop_value),
  .out_status    (out_status),
  .out_occupancy (out_occupancy)
);

`default_nettype wire
